// ===== src/tod_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tod_pkg;

  // Result kinds
  localparam logic [1:0] KIND_TIME       = 2'd0;
  localparam logic [1:0] KIND_SET_ECHO   = 2'd1;
  localparam logic [1:0] KIND_TEXT_CHAR  = 2'd2;
  localparam logic [1:0] KIND_TEXT_BEGIN = 2'd3;

  // Input modes
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_BYTE = 1'b1;

  // Characters the parser reacts to
  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_HASH   = 8'd35;
  localparam logic [7:0] CH_STAR   = 8'd42;

  // Number of set-command bytes stored before the last one arrives
  localparam int unsigned SET_STORED = 7;
  localparam logic [2:0]  SET_LAST   = 3'(SET_STORED);

  // Time held as BCD digits
  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_ones;
    logic [2:0] minute_tens;
    logic [3:0] minute_ones;
    logic [2:0] second_tens;
    logic [3:0] second_ones;
  } tod_time_t;

  // Control from the parser to the time keeper
  typedef struct packed {
    logic tick;
    logic load;
  } tod_ctrl_t;

  // ASCII digit '0'..'9' check
  function automatic logic is_digit(input logic [7:0] b);
    return (b[7:4] == 4'h3) && (b[3:0] <= 4'd9);
  endfunction

  // BCD digit to 6-bit ASCII ('0' is 6'b110000)
  function automatic logic [5:0] to_ascii(input logic [3:0] d);
    return {2'b11, d};
  endfunction

endpackage

`default_nettype wire

// ===== src/tod_time.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tod_time
  import tod_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire tod_ctrl_t ctrl,
  input  wire tod_time_t load_value,
  output tod_time_t      time_next
);

  tod_time_t time_reg;
  tod_time_t inc;
  logic      c_s, c_st, c_m, c_mt;

  // BCD increment with 24-hour wrap
  always_comb begin
    inc  = time_reg;
    c_s  = (time_reg.second_ones == 4'd9);
    c_st = c_s && (time_reg.second_tens == 3'd5);
    c_m  = c_st && (time_reg.minute_ones == 4'd9);
    c_mt = c_m && (time_reg.minute_tens == 3'd5);
    inc.second_ones = c_s ? 4'd0 : time_reg.second_ones + 4'd1;
    if (c_s) begin
      inc.second_tens = c_st ? 3'd0 : time_reg.second_tens + 3'd1;
    end
    if (c_st) begin
      inc.minute_ones = c_m ? 4'd0 : time_reg.minute_ones + 4'd1;
    end
    if (c_m) begin
      inc.minute_tens = c_mt ? 3'd0 : time_reg.minute_tens + 3'd1;
    end
    if (c_mt) begin
      if (time_reg.hour_tens == 2'd2 && time_reg.hour_ones == 4'd3) begin
        inc.hour_tens = 2'd0;
        inc.hour_ones = 4'd0;
      end else if (time_reg.hour_ones == 4'd9) begin
        inc.hour_tens = time_reg.hour_tens + 2'd1;
        inc.hour_ones = 4'd0;
      end else begin
        inc.hour_ones = time_reg.hour_ones + 4'd1;
      end
    end
  end

  always_comb begin
    if (ctrl.tick) begin
      time_next = inc;
    end else if (ctrl.load) begin
      time_next = load_value;
    end else begin
      time_next = time_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_reg <= '0;
    end else begin
      time_reg <= time_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/time_of_day_clock_serial_set.sv =====
`timescale 1ns / 1ps
`default_nettype none

// 24-hour time-of-day clock with a serial set command. Each input transfer is
// either a one-second tick (mode 0) or a received serial byte (mode 1). A tick
// advances the time and returns the six ASCII digits of the new time. Bytes
// feed a parser: '$' followed by eight bytes hh?mm?ss loads the time (each of
// the eight bytes is echoed; the last echo flags set_done and, if a digit was
// bad or the value out of range, set_error with the time left as it was);
// '#' enters text mode, answered by a text-begin result, after which nonzero
// bytes are echoed as text until '*'. Every result carries the time as it
// stands after that item. The time and parser state update at the accepting
// edge and the result lands in a single output register, so a new transfer
// is taken every cycle as long as the output register is empty or being
// drained in the same cycle. Items that produce no result ('$', '*', dropped
// bytes) are still accepted only while in_ready is high.
module time_of_day_clock_serial_set
  import tod_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // Input channel
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       mode,
  input  wire logic [7:0] rx_byte,
  // Output channel
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      kind,
  output logic [7:0]      out_byte,
  output logic [5:0]      hour_tens,
  output logic [5:0]      hour_ones,
  output logic [5:0]      minute_tens,
  output logic [5:0]      minute_ones,
  output logic [5:0]      second_tens,
  output logic [5:0]      second_ones,
  output logic            set_done,
  output logic            set_error
);

  typedef enum logic [1:0] {
    PM_IDLE,
    PM_SET,
    PM_TEXT
  } parse_t;

  parse_t     parse_mode, parse_mode_next;
  logic [2:0] set_count, set_count_next;
  logic [7:0] set_bytes [SET_STORED];

  logic       in_xfer;
  logic       res_valid;
  logic [1:0] res_kind;
  logic [7:0] res_byte;
  logic       res_done;
  logic       res_error;
  logic       store_byte;
  logic       set_ok;

  tod_ctrl_t  ctrl;
  tod_time_t  load_value;
  tod_time_t  time_next;

  // Output register can take a new result when empty or draining this cycle.
  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // Candidate time from the stored command bytes plus the last byte.
  // Separator bytes (positions 2 and 5) are never looked at.
  always_comb begin
    load_value.hour_tens   = set_bytes[0][1:0];
    load_value.hour_ones   = set_bytes[1][3:0];
    load_value.minute_tens = set_bytes[3][2:0];
    load_value.minute_ones = set_bytes[4][3:0];
    load_value.second_tens = set_bytes[6][2:0];
    load_value.second_ones = rx_byte[3:0];
    set_ok = is_digit(set_bytes[0]) && is_digit(set_bytes[1]) &&
             is_digit(set_bytes[3]) && is_digit(set_bytes[4]) &&
             is_digit(set_bytes[6]) && is_digit(rx_byte) &&
             // hours below 24
             ((set_bytes[0][3:0] < 4'd2) ||
              (set_bytes[0][3:0] == 4'd2 && set_bytes[1][3:0] <= 4'd3)) &&
             // minutes and seconds below 60
             (set_bytes[3][3:0] <= 4'd5) && (set_bytes[6][3:0] <= 4'd5);
  end

  // Parser: decides result, state change and time update for this item.
  always_comb begin
    parse_mode_next = parse_mode;
    set_count_next  = set_count;
    res_valid       = 1'b0;
    res_kind        = KIND_TIME;
    res_byte        = 8'd0;
    res_done        = 1'b0;
    res_error       = 1'b0;
    store_byte      = 1'b0;
    ctrl            = '0;
    if (mode == MODE_TICK) begin
      ctrl.tick = 1'b1;
      res_valid = 1'b1;
    end else begin
      unique case (parse_mode)
        PM_SET: begin
          res_valid = 1'b1;
          res_kind  = KIND_SET_ECHO;
          res_byte  = rx_byte;
          if (set_count != SET_LAST) begin
            store_byte     = 1'b1;
            set_count_next = set_count + 3'd1;
          end else begin
            // last byte: check and load
            ctrl.load       = set_ok;
            res_done        = 1'b1;
            res_error       = !set_ok;
            parse_mode_next = PM_IDLE;
            set_count_next  = 3'd0;
          end
        end
        PM_TEXT: begin
          if (rx_byte == CH_STAR) begin
            parse_mode_next = PM_IDLE;
          end else if (rx_byte != 8'd0) begin
            res_valid = 1'b1;
            res_kind  = KIND_TEXT_CHAR;
            res_byte  = rx_byte;
          end
        end
        default: begin
          if (rx_byte == CH_DOLLAR) begin
            parse_mode_next = PM_SET;
            set_count_next  = 3'd0;
          end else if (rx_byte == CH_HASH) begin
            parse_mode_next = PM_TEXT;
            res_valid       = 1'b1;
            res_kind        = KIND_TEXT_BEGIN;
          end
        end
      endcase
    end
    // Nothing changes without a transfer
    if (!in_xfer) begin
      ctrl.tick = 1'b0;
      ctrl.load = 1'b0;
    end
  end

  tod_time u_time (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .load_value (load_value),
    .time_next  (time_next)
  );

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_mode <= PM_IDLE;
      set_count  <= 3'd0;
    end else if (in_xfer) begin
      parse_mode <= parse_mode_next;
      set_count  <= set_count_next;
    end
  end

  // Command byte store; every entry read is written earlier in the command.
  always_ff @(posedge clk) begin
    if (in_xfer && store_byte) begin
      set_bytes[set_count] <= rx_byte;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && res_valid) begin
      kind        <= res_kind;
      out_byte    <= res_byte;
      hour_tens   <= to_ascii({2'b00, time_next.hour_tens});
      hour_ones   <= to_ascii(time_next.hour_ones);
      minute_tens <= to_ascii({1'b0, time_next.minute_tens});
      minute_ones <= to_ascii(time_next.minute_ones);
      second_tens <= to_ascii({1'b0, time_next.second_tens});
      second_ones <= to_ascii(time_next.second_ones);
      set_done    <= res_done;
      set_error   <= res_error;
    end
  end

endmodule

`default_nettype wire

// ===== verif/time_of_day_clock_serial_set_test.sv =====
`timescale 1ns / 1ps

// Drives ticks and serial bytes into the time-of-day clock, predicts every
// display/echo/text result with a behavioral copy of the clock and parser,
// and checks each output transfer in order against that prediction.
module time_of_day_clock_serial_set_test;
  import tod_pkg::*;

  localparam int ASCII_ZERO   = 48;
  localparam int RANDOM_ITEMS = 1150;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  // Parser state of the predictor
  typedef enum logic [1:0] {
    PARSE_IDLE = 2'd0,
    PARSE_SET  = 2'd1,
    PARSE_TEXT = 2'd2
  } parse_state_t;

  // One output transfer, field for field as on the ports
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [5:0] hour_tens;
    logic [5:0] hour_ones;
    logic [5:0] minute_tens;
    logic [5:0] minute_ones;
    logic [5:0] second_tens;
    logic [5:0] second_ones;
    logic       set_done;
    logic       set_error;
  } display_t;

  // One input transfer. Rows with 'typed' set carry their expected result
  // written out by hand; hms holds "hhmmss" as six ASCII characters.
  typedef struct {
    logic        mode;
    logic [7:0]  rx;
    bit          typed;
    logic [1:0]  kind;
    logic [7:0]  echo;
    logic [47:0] hms;
    bit          done;
    bit          err;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 27;

  // Directed walk: first tick, ignored idle byte, a good set command with a
  // tick in the middle and an 0xFF separator, full wrap at midnight, an hour
  // of 24 rejected, then text mode with a dropped zero, 0xFF, '$' as text and
  // the closing '*'.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{MODE_TICK, 8'h00, 1, KIND_TIME,       8'h00, "000001", 0, 0},
    '{MODE_BYTE, "A",   0, KIND_TIME,       8'h00, "000000", 0, 0},
    '{MODE_BYTE, "$",   0, KIND_TIME,       8'h00, "000000", 0, 0},
    '{MODE_BYTE, "2",   0, KIND_TIME,       8'h00, "000000", 0, 0},
    '{MODE_BYTE, "3",   0, KIND_TIME,       8'h00, "000000", 0, 0},
    '{MODE_BYTE, ":",   0, KIND_TIME,       8'h00, "000000", 0, 0},
    '{MODE_BYTE, "5",   0, KIND_TIME,       8'h00, "000000", 0, 0},
    '{MODE_TICK, 8'h00, 1, KIND_TIME,       8'h00, "000002", 0, 0},
    '{MODE_BYTE, "9",   0, KIND_TIME,       8'h00, "000000", 0, 0},
    '{MODE_BYTE, 8'hFF, 0, KIND_TIME,       8'h00, "000000", 0, 0},
    '{MODE_BYTE, "5",   0, KIND_TIME,       8'h00, "000000", 0, 0},
    '{MODE_BYTE, "9",   1, KIND_SET_ECHO,   "9",   "235959", 1, 0},
    '{MODE_TICK, 8'hA5, 1, KIND_TIME,       8'h00, "000000", 0, 0},
    '{MODE_BYTE, "$",   0, KIND_TIME,       8'h00, "000000", 0, 0},
    '{MODE_BYTE, "2",   0, KIND_TIME,       8'h00, "000000", 0, 0},
    '{MODE_BYTE, "4",   0, KIND_TIME,       8'h00, "000000", 0, 0},
    '{MODE_BYTE, ":",   0, KIND_TIME,       8'h00, "000000", 0, 0},
    '{MODE_BYTE, "0",   0, KIND_TIME,       8'h00, "000000", 0, 0},
    '{MODE_BYTE, "0",   0, KIND_TIME,       8'h00, "000000", 0, 0},
    '{MODE_BYTE, ":",   0, KIND_TIME,       8'h00, "000000", 0, 0},
    '{MODE_BYTE, "0",   0, KIND_TIME,       8'h00, "000000", 0, 0},
    '{MODE_BYTE, "0",   1, KIND_SET_ECHO,   "0",   "000000", 1, 1},
    '{MODE_BYTE, "#",   1, KIND_TEXT_BEGIN, 8'h00, "000000", 0, 0},
    '{MODE_BYTE, 8'h00, 0, KIND_TIME,       8'h00, "000000", 0, 0},
    '{MODE_BYTE, 8'hFF, 1, KIND_TEXT_CHAR,  8'hFF, "000000", 0, 0},
    '{MODE_BYTE, "$",   0, KIND_TIME,       8'h00, "000000", 0, 0},
    '{MODE_BYTE, "*",   0, KIND_TIME,       8'h00, "000000", 0, 0}
  };

  // DUT ports, all inputs known from time zero
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       mode = MODE_TICK;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [5:0] hour_tens;
  logic [5:0] hour_ones;
  logic [5:0] minute_tens;
  logic [5:0] minute_ones;
  logic [5:0] second_tens;
  logic [5:0] second_ones;
  logic       set_done;
  logic       set_error;

  time_of_day_clock_serial_set dut (.*);

  // Predicted clock and parser state
  logic [5:0]   sec_now = '0;
  logic [5:0]   min_now = '0;
  logic [4:0]   hr_now = '0;
  parse_state_t parse_now = PARSE_IDLE;
  logic [2:0]   set_cnt = '0;
  logic [7:0]   set_buf [SET_STORED];

  stim_row_t stim_q [$];
  display_t  pending_displays [$];
  stim_row_t cur_row;
  bit        item_offered = 1'b0;   // an input transfer is on the port
  int        items_sent = 0;
  int        idle_phase = 0;
  int        errors = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Result carrying the time as it stands now
  function automatic display_t reading(input logic [1:0] k, input logic [7:0] b,
                                       input logic d, input logic e);
    display_t r;
    r.kind        = k;
    r.out_byte    = b;
    r.hour_tens   = 6'(ASCII_ZERO + hr_now / 10);
    r.hour_ones   = 6'(ASCII_ZERO + hr_now % 10);
    r.minute_tens = 6'(ASCII_ZERO + min_now / 10);
    r.minute_ones = 6'(ASCII_ZERO + min_now % 10);
    r.second_tens = 6'(ASCII_ZERO + sec_now / 10);
    r.second_ones = 6'(ASCII_ZERO + sec_now % 10);
    r.set_done    = d;
    r.set_error   = e;
    return r;
  endfunction

  function automatic bit ascii_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  // Applies one input transfer to the predicted state; 'made' tells whether
  // the transfer produces a result.
  task automatic clock_apply_item(input logic m, input logic [7:0] b,
                                  output bit made, output display_t res);
    int  h;
    int  mi;
    int  s;
    bit  rejected;
    made = 1'b0;
    res  = '0;
    if (m == MODE_TICK) begin
      // seconds carry into minutes, minutes into hours, wrap at 24:00:00
      sec_now = sec_now + 6'd1;
      if (sec_now >= 6'd60) begin
        sec_now = '0;
        min_now = min_now + 6'd1;
      end
      if (min_now >= 6'd60) begin
        min_now = '0;
        hr_now  = hr_now + 5'd1;
      end
      if (hr_now >= 5'd24) hr_now = '0;
      made = 1'b1;
      res  = reading(KIND_TIME, 8'h00, 1'b0, 1'b0);
    end else if (parse_now == PARSE_SET) begin
      made = 1'b1;
      if (set_cnt != SET_LAST) begin
        // any byte counts toward the command, separators included
        set_buf[set_cnt] = b;
        set_cnt = set_cnt + 3'd1;
        res = reading(KIND_SET_ECHO, b, 1'b0, 1'b0);
      end else begin
        rejected = !ascii_digit(set_buf[0]) || !ascii_digit(set_buf[1]) ||
                   !ascii_digit(set_buf[3]) || !ascii_digit(set_buf[4]) ||
                   !ascii_digit(set_buf[6]) || !ascii_digit(b);
        h  = (set_buf[0] - ASCII_ZERO) * 10 + (set_buf[1] - ASCII_ZERO);
        mi = (set_buf[3] - ASCII_ZERO) * 10 + (set_buf[4] - ASCII_ZERO);
        s  = (set_buf[6] - ASCII_ZERO) * 10 + (b - ASCII_ZERO);
        if (!rejected && (h >= 24 || mi >= 60 || s >= 60)) rejected = 1'b1;
        if (!rejected) begin
          hr_now  = 5'(h);
          min_now = 6'(mi);
          sec_now = 6'(s);
        end
        parse_now = PARSE_IDLE;
        set_cnt   = '0;
        res = reading(KIND_SET_ECHO, b, 1'b1, rejected);
      end
    end else if (parse_now == PARSE_TEXT) begin
      if (b == CH_STAR) begin
        parse_now = PARSE_IDLE;
      end else if (b != 8'h00) begin
        made = 1'b1;
        res  = reading(KIND_TEXT_CHAR, b, 1'b0, 1'b0);
      end
    end else if (b == CH_DOLLAR) begin
      parse_now = PARSE_SET;
      set_cnt   = '0;
    end else if (b == CH_HASH) begin
      parse_now = PARSE_TEXT;
      made = 1'b1;
      res  = reading(KIND_TEXT_BEGIN, 8'h00, 1'b0, 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------

  task automatic push_item(input logic m, input logic [7:0] b);
    stim_row_t r;
    r       = '{default: '0};
    r.mode  = m;
    r.rx    = b;
    r.typed = 1'b0;
    stim_q.push_back(r);
  endtask

  // '$' plus hh?mm?ss, biased toward the rollover edges; about a quarter
  // carry a bad digit or an out-of-range value, some have a tick inside.
  task automatic push_set_command(inout int count);
    int         h;
    int         mi;
    int         s;
    int         p;
    int         tick_at;
    logic [7:0] cmd [8];
    int         digit_pos [6] = '{0, 1, 3, 4, 6, 7};
    h  = ($urandom_range(3) == 0) ? 23 : $urandom_range(23);
    mi = ($urandom_range(3) == 0) ? 59 : $urandom_range(59);
    s  = ($urandom_range(3) == 0) ? $urandom_range(59, 50) : $urandom_range(59);
    cmd[0] = 8'(ASCII_ZERO + h / 10);
    cmd[1] = 8'(ASCII_ZERO + h % 10);
    cmd[2] = 8'($urandom_range(255));
    cmd[3] = 8'(ASCII_ZERO + mi / 10);
    cmd[4] = 8'(ASCII_ZERO + mi % 10);
    cmd[5] = 8'($urandom_range(255));
    cmd[6] = 8'(ASCII_ZERO + s / 10);
    cmd[7] = 8'(ASCII_ZERO + s % 10);
    if ($urandom_range(3) == 0) begin
      p = digit_pos[$urandom_range(5)];
      case ($urandom_range(3))
        0: cmd[p] = 8'($urandom_range(255));
        1: cmd[p] = $urandom_range(1) ? "/" : ":";   // just outside '0'..'9'
        2: cmd[$urandom_range(1) ? 3 : 6] = 8'($urandom_range("9", "6"));
        default: begin
          cmd[0] = "2";
          cmd[1] = 8'($urandom_range("9", "4"));
        end
      endcase
    end
    tick_at = ($urandom_range(9) == 0) ? $urandom_range(7) : -1;
    push_item(MODE_BYTE, CH_DOLLAR);
    count++;
    for (int i = 0; i < 8; i++) begin
      if (i == tick_at) begin
        push_item(MODE_TICK, 8'($urandom_range(255)));
        count++;
      end
      push_item(MODE_BYTE, cmd[i]);
      count++;
    end
    // a few ticks right after a load reach the carries
    repeat ($urandom_range(3)) begin
      push_item(MODE_TICK, 8'($urandom_range(255)));
      count++;
    end
  endtask

  // '#', a few bytes (zeros and the odd tick among them), mostly closed by '*'
  task automatic push_text_run(inout int count);
    logic [7:0] b;
    push_item(MODE_BYTE, CH_HASH);
    count++;
    repeat ($urandom_range(6, 1)) begin
      if ($urandom_range(9) == 0) begin
        push_item(MODE_TICK, 8'($urandom_range(255)));
      end else begin
        b = ($urandom_range(6) == 0) ? 8'h00 : 8'($urandom_range(255));
        push_item(MODE_BYTE, b);
      end
      count++;
    end
    if ($urandom_range(6) != 0) begin
      push_item(MODE_BYTE, CH_STAR);
      count++;
    end
  endtask

  task automatic build_stimulus();
    int count;
    int pick;
    count = 0;
    foreach (directed_rows[i]) stim_q.push_back(directed_rows[i]);
    while (count < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        push_item(MODE_TICK, 8'($urandom_range(255)));
        count++;
      end else if (pick < 65) begin
        push_set_command(count);
      end else if (pick < 85) begin
        push_text_run(count);
      end else begin
        // noise in idle; mostly ignored, so not counted
        push_item(MODE_BYTE, 8'($urandom_range(255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  function automatic string show(input display_t d);
    return $sformatf("kind=%0d byte=%02h time=%c%c:%c%c:%c%c done=%0d err=%0d",
                     d.kind, d.out_byte, 8'(d.hour_tens), 8'(d.hour_ones),
                     8'(d.minute_tens), 8'(d.minute_ones), 8'(d.second_tens),
                     8'(d.second_ones), d.set_done, d.set_error);
  endfunction

  task automatic note_failure(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
  endtask

  // Sample at the rising edge: input transfer first, then output transfer
  always @(posedge clk) begin
    bit       made;
    display_t res;
    display_t got;
    display_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        clock_apply_item(mode, rx_byte, made, res);
        if (cur_row.typed) begin
          res.kind        = cur_row.kind;
          res.out_byte    = cur_row.echo;
          res.hour_tens   = cur_row.hms[45:40];
          res.hour_ones   = cur_row.hms[37:32];
          res.minute_tens = cur_row.hms[29:24];
          res.minute_ones = cur_row.hms[21:16];
          res.second_tens = cur_row.hms[13:8];
          res.second_ones = cur_row.hms[5:0];
          res.set_done    = cur_row.done;
          res.set_error   = cur_row.err;
          made = 1'b1;
        end
        if (made) pending_displays.push_back(res);
        item_offered = 1'b0;
      end
      if (out_valid && out_ready) begin
        got = '{kind, out_byte, hour_tens, hour_ones, minute_tens, minute_ones,
                second_tens, second_ones, set_done, set_error};
        if (pending_displays.size() == 0) begin
          note_failure({"unexpected result: ", show(got)});
        end else begin
          want = pending_displays.pop_front();
          if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
              got.hour_tens !== want.hour_tens || got.hour_ones !== want.hour_ones ||
              got.minute_tens !== want.minute_tens ||
              got.minute_ones !== want.minute_ones ||
              got.second_tens !== want.second_tens ||
              got.second_ones !== want.second_ones ||
              got.set_done !== want.set_done || got.set_error !== want.set_error)
            note_failure({"mismatch: expected ", show(want), " actual ", show(got)});
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driving at the falling edge: sender and receiver
  // ---------------------------------------------------------------------

  // Idling phases rotate every 60 items: none, sender 54%, receiver 54%,
  // both 38%.
  always @(negedge clk) begin
    int send_idle;
    int recv_stall;
    idle_phase = (items_sent / 60) % 4;
    send_idle  = (idle_phase == 1) ? 54 : (idle_phase == 3) ? 38 : 0;
    recv_stall = (idle_phase == 2) ? 54 : (idle_phase == 3) ? 38 : 0;
    out_ready <= ($urandom_range(99) >= recv_stall);
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!item_offered) begin
      // a held transfer keeps valid and payload untouched
      if (stim_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        cur_row = stim_q.pop_front();
        in_valid <= 1'b1;
        mode     <= cur_row.mode;
        rx_byte  <= cur_row.rx;
        item_offered = 1'b1;
        items_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------

  initial begin
    build_stimulus();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (stim_q.size() != 0 || item_offered) @(posedge clk);
    while (pending_displays.size() != 0) @(posedge clk);
    // a short tail catches any stray extra result
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_displays.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_displays.size()));
    if (errors == 0) begin
      $display("time_of_day_clock_serial_set_test: PASS");
    end else begin
      $display("time_of_day_clock_serial_set_test: FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("time_of_day_clock_serial_set_test: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
src/tod_pkg.sv
src/tod_time.sv
src/time_of_day_clock_serial_set.sv
verif/time_of_day_clock_serial_set_test.sv
